// ===== rtl/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg
// shared types, constants and coefficient table for the degree sine/cosine
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int AngleW = 16;
  localparam int ValueW = 15;
  localparam int AccW   = 32;
  localparam int TW     = 7;
  localparam int NumCells = 4;

  localparam int DegFull   = 360;
  localparam int DegHalf   = 180;
  localparam int DegRight  = 90;
  localparam int DegEighth = 45;

  // divide by 10000 = shift 4 then divide by 625
  // divide by 100000 = shift 5 then divide by 3125
  localparam int QuotInW = 25;
  localparam int RecipW  = 26;
  localparam int ProdW   = QuotInW + RecipW;
  localparam int QuotW   = 14;
  localparam logic [RecipW-1:0] RecipLo = 26'd54975582;
  localparam logic [RecipW-1:0] RecipHi = 26'd43980466;
  localparam int ShiftLo = 35;
  localparam int ShiftHi = 37;

  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    acc_t          acc;
    logic [TW-1:0] t;
    logic          hi;
    logic          neg;
  } scd_item_t;

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } scd_op_t;

  // cubic coefficients, highest power first
  function automatic acc_t poly_coef(input logic hi, input logic [1:0] k);
    acc_t c;
    c = '0;
    case ({hi, k})
      3'b000:  c = -32'sd81;
      3'b001:  c = -32'sd277;
      3'b010:  c = 32'sd1747900;
      3'b011:  c = -32'sd1600;
      3'b100:  c = 32'sd336;
      3'b101:  c = -32'sd161420;
      3'b110:  c = 32'sd75484;
      3'b111:  c = 32'sd999960000;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/scd_in_if.sv =====
// ----------------------------------------------------------------------------
// scd_in_if
// angle request channel: opcode and integer angle in degrees
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [15:0]        angle_deg;

  modport source (output valid, output opcode, output angle_deg, input ready);
  modport sink   (input valid, input opcode, input angle_deg, output ready);
endinterface

// ===== rtl/scd_out_if.sv =====
// ----------------------------------------------------------------------------
// scd_out_if
// result channel: value in ten-thousandths
// ----------------------------------------------------------------------------
interface scd_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [14:0]        value_e4;

  modport source (output valid, output value_e4, input ready);
  modport sink   (input valid, input value_e4, output ready);
endinterface

// ===== rtl/sine_cosine_degrees_fixed.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_degrees_fixed
// integer-degree sine/cosine in ten-thousandths, cubic fit per half quadrant
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                      meaning
//   in_ch     in    opcode, angle_deg[15:0]      0 sine / 1 cosine, degrees
//   out_ch    out   value_e4[14:0]               result * 10000, signed
//
// one transaction accepted per cycle while out_ch is not stalled; 10 register
// stages (3 reduction, 4 horner cells, 3 divide)
// the whole pipe advances together whenever the output register is empty
// or being taken, so a stall on out_ch freezes every stage in place
// synchronous reset clears only the valid bits
//
module sine_cosine_degrees_fixed (
  input  logic       clk,
  input  logic       rst,
  scd_in_if.sink     in_ch,
  scd_out_if.source  out_ch
);
  import scd_pkg::*;

  // global advance: the last stage is the output register
  logic en;

  logic       cell_valid [NumCells+1];
  scd_item_t  cell_item  [NumCells+1];

  assign en          = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = en;

  // fold the angle into 0..90, note sign and which cubic applies
  scd_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .opcode    (in_ch.opcode),
    .angle_deg (in_ch.angle_deg),
    .out_valid (cell_valid[0]),
    .out_item  (cell_item[0])
  );

  // chain of horner cells, one coefficient each, highest power first
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    scd_cell #(
      .K (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cell_valid[g]),
      .in_item   (cell_item[g]),
      .out_valid (cell_valid[g+1]),
      .out_item  (cell_item[g+1])
    );
  end

  // scale down and apply sign, ends in the output register
  scd_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cell_valid[NumCells]),
    .in_item   (cell_item[NumCells]),
    .out_valid (out_ch.valid),
    .value_e4  (out_ch.value_e4)
  );

endmodule

// ===== rtl/scd_reduce.sv =====
// ----------------------------------------------------------------------------
// scd_reduce
// three-stage angle reduction: sign split, mod 360, fold into 0..90
// ----------------------------------------------------------------------------
module scd_reduce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      opcode,
  input  logic signed [15:0]        angle_deg,
  output logic                      out_valid,
  output scd_pkg::scd_item_t        out_item
);
  import scd_pkg::*;

  logic                v1, v2;
  logic                neg1, neg2;
  logic [AngleW-1:0]   mag1;
  logic [8:0]          rem2;

  logic signed [AngleW:0] sum;
  logic [AngleW:0]        sum_abs;
  logic [AngleW-1:0]      r;
  logic [8:0]             m_a, m_b;
  logic                   neg_f;
  logic [TW-1:0]          t_f;
  logic                   hi_f;

  // stage 1: cosine offset, sign and magnitude
  always_comb begin
    sum = {angle_deg[AngleW-1], angle_deg} +
          ((opcode == OP_COSINE) ? (AngleW+1)'(DegRight) : '0);
    sum_abs = sum[AngleW] ? (AngleW+1)'(-sum) : (AngleW+1)'(sum);
  end

  // stage 2: restoring mod 360
  always_comb begin
    r = mag1;
    for (int k = 6; k >= 0; k--) begin
      if (r >= AngleW'(DegFull << k)) begin
        r = r - AngleW'(DegFull << k);
      end
    end
  end

  // stage 3: fold into the first quadrant
  always_comb begin
    neg_f = neg2;
    m_a   = rem2;
    if (rem2 > 9'(DegHalf)) begin
      neg_f = ~neg2;
      m_a   = rem2 - 9'(DegHalf);
    end
    m_b = (m_a > 9'(DegRight)) ? 9'(DegHalf) - m_a : m_a;
    hi_f = (m_b > 9'(DegEighth));
    t_f  = hi_f ? TW'(9'(DegRight) - m_b) : TW'(m_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= sum[AngleW];
      mag1 <= sum_abs[AngleW-1:0];
      neg2 <= neg1;
      rem2 <= r[8:0];
      out_item.acc <= '0;
      out_item.t   <= t_f;
      out_item.hi  <= hi_f;
      out_item.neg <= neg_f;
    end
  end

endmodule

// ===== rtl/scd_cell.sv =====
// ----------------------------------------------------------------------------
// scd_cell
// one horner step: acc = acc * t + coefficient
// ----------------------------------------------------------------------------
module scd_cell #(
  parameter int K = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  scd_pkg::scd_item_t        in_item,
  output logic                      out_valid,
  output scd_pkg::scd_item_t        out_item
);
  import scd_pkg::*;

  logic signed [AccW+TW:0] prod;
  acc_t                    acc_next;

  always_comb begin
    prod     = in_item.acc * $signed({1'b0, in_item.t});
    acc_next = acc_t'(prod[AccW-1:0]) + poly_coef(in_item.hi, 2'(K));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.acc <= acc_next;
      out_item.t   <= in_item.t;
      out_item.hi  <= in_item.hi;
      out_item.neg <= in_item.neg;
    end
  end

endmodule

// ===== rtl/scd_divide.sv =====
// ----------------------------------------------------------------------------
// scd_divide
// truncating divide by 10000 or 100000 via reciprocal multiply, signed result
// ----------------------------------------------------------------------------
module scd_divide (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  scd_pkg::scd_item_t        in_item,
  output logic                      out_valid,
  output logic signed [14:0]        value_e4
);
  import scd_pkg::*;

  logic                 va, vb;
  logic                 sgn_a, sgn_b, hi_a, hi_b;
  logic [QuotInW-1:0]   n_a;
  logic [ProdW-1:0]     prod_b;

  logic [AccW-1:0]      mag;
  logic [AccW-1:0]      shifted;
  logic [QuotW-1:0]     quot;

  always_comb begin
    mag     = in_item.acc[AccW-1] ? AccW'(-in_item.acc) : AccW'(in_item.acc);
    shifted = in_item.hi ? (mag >> 5) : (mag >> 4);
    quot    = hi_b ? QuotW'(prod_b >> ShiftHi) : QuotW'(prod_b >> ShiftLo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_a  <= in_item.acc[AccW-1] ^ in_item.neg;
      hi_a   <= in_item.hi;
      n_a    <= shifted[QuotInW-1:0];
      sgn_b  <= sgn_a;
      hi_b   <= hi_a;
      prod_b <= ProdW'(n_a) * ProdW'(hi_a ? RecipHi : RecipLo);
      value_e4 <= sgn_b ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end
  end

endmodule
